/* hw/rtl/confidence_priority_queue_assert.svh */
// Assertion macros for the queue RTL.
`ifndef CONFIDENCE_PRIORITY_QUEUE_ASSERT_SVH
`define CONFIDENCE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/cpq_pkg.sv */
`default_nettype none

package cpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int LIST_MAX    = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_POP    = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_COUNTS = 3'd4
    } t_cmd_code;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_UPD_INS,
        S_LIST
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     match_en;
    } t_cell_ctrl;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] case_id;
        logic [31:0] owner_id;
        logic [15:0] confidence;
        logic        pending;
        logic [4:0]  list_limit;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] case_id_res;
        logic [31:0] owner_id_res;
        logic [15:0] confidence_res;
        logic        pending_res;
        logic [4:0]  total_count;
        logic [4:0]  pending_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] case_id;
        logic [31:0] owner_id;
        logic [15:0] confidence;
        logic        pending;
    } t_rec;

    // Counts are reported in five bits.
    function automatic logic [4:0] cnt5(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] t;
        t = (CNT_W + 5)'(c);
        return t[4:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cpq_cell.sv */
`default_nettype none

module cpq_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  cpq_pkg::t_cell_ctrl  i_ctrl,
    input  cpq_pkg::t_rec        i_new,
    input  cpq_pkg::t_rec        i_left_rec,
    input  wire                  i_left_valid,
    input  wire                  i_left_keep,
    input  cpq_pkg::t_rec        i_right_rec,
    input  wire                  i_right_valid,
    input  wire                  i_hit_in,
    output cpq_pkg::t_rec        o_rec,
    output logic                 o_valid,
    output logic                 o_keep,
    output logic                 o_hit,
    output logic                 o_taken_pend
);
    import cpq_pkg::*;

    t_rec r_rec, n_rec;
    logic r_valid, n_valid;
    logic w_match;
    logic w_shift;

    // Entries of equal confidence stay ahead of a new arrival.
    assign o_keep  = r_valid && (r_rec.confidence >= i_new.confidence);
    assign w_match = i_ctrl.match_en && r_valid && (r_rec.case_id == i_new.case_id);
    assign w_shift = i_hit_in | w_match;
    assign o_hit   = w_shift;
    assign o_taken_pend = w_match & ~i_hit_in & r_rec.pending;
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    if (i_left_keep) begin
                        n_rec   = i_new;
                        n_valid = 1'b1;
                    end else begin
                        n_rec   = i_left_rec;
                        n_valid = i_left_valid;
                    end
                end
            end
            CELL_REMOVE: begin
                // Close the gap from the first hit onward.
                if (w_shift) begin
                    n_rec   = i_right_rec;
                    n_valid = i_right_valid;
                end
            end
            CELL_ROTATE: begin
                n_rec   = i_right_rec;
                n_valid = i_right_valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

`default_nettype wire

/* hw/rtl/confidence_priority_queue.sv */
// Channel   Handshake              Payload
// command   start, busy (input)    i_cmd   (t_cmd_in)
// result    o_valid strobe         o_result (t_result)
//
// A command is taken when start is high and busy is low.
// Insert, pop, counts, an empty list and an update that misses its id return their
// result from the S_EXEC state; an update that finds its id returns it from S_UPD_INS.
// List keeps busy while the cell row rotates one slot per cycle through a full turn
// and cell 0 streams out one entry per cycle, front first, up to the list limit.
// Each result is flagged by o_valid for one cycle only; the receiver cannot stall.
// Reset is synchronous, active low, and empties the queue.
`default_nettype none

module confidence_priority_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  cpq_pkg::t_cmd_in  i_cmd,
    output logic              o_valid,
    output cpq_pkg::t_result  o_result
);
    import cpq_pkg::*;

    localparam int LW = IDX_W + 5;
    localparam int CW = CNT_W + 5;

    t_state             r_state, n_state;
    t_cmd_in            r_req;
    t_rec               w_new;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_pcount, n_pcount;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [4:0]         r_n, n_n;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    t_cell_ctrl         w_ctrl;
    logic               w_pop_front;
    t_rec               w_rec      [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_hit;
    logic [QUEUE_DEPTH-1:0] w_taken_pend;
    t_rec               w_tail_rec;
    logic               w_tail_valid;
    logic               w_found;
    logic               w_full;
    logic [4:0]         w_lim;
    logic [4:0]         w_list_n;

    assign w_new = '{case_id:    r_req.case_id,
                     owner_id:   r_req.owner_id,
                     confidence: r_req.confidence,
                     pending:    r_req.pending};

    // Rotation wraps cell 0 to the tail; removal feeds an empty slot.
    assign w_tail_rec   = w_rec[0];
    assign w_tail_valid = (w_ctrl.op == CELL_ROTATE) ? w_valid[0] : 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            cpq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new         (w_new),
                .i_left_rec    ((g == 0) ? w_new : w_rec[(g == 0) ? 0 : g - 1]),
                .i_left_valid  ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g - 1]),
                .i_left_keep   ((g == 0) ? 1'b1 : w_keep[(g == 0) ? 0 : g - 1]),
                .i_right_rec   ((g == QUEUE_DEPTH - 1) ? w_tail_rec
                                : w_rec[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .i_right_valid ((g == QUEUE_DEPTH - 1) ? w_tail_valid
                                : w_valid[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .i_hit_in      ((g == 0) ? w_pop_front : w_hit[(g == 0) ? 0 : g - 1]),
                .o_rec         (w_rec[g]),
                .o_valid       (w_valid[g]),
                .o_keep        (w_keep[g]),
                .o_hit         (w_hit[g]),
                .o_taken_pend  (w_taken_pend[g])
            );
        end
    endgenerate

    assign w_found = w_hit[QUEUE_DEPTH-1];
    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_lim   = (r_req.list_limit > 5'(LIST_MAX)) ? 5'(LIST_MAX) : r_req.list_limit;
    assign w_list_n = (CW'(r_count) < CW'(w_lim)) ? cnt5(r_count) : w_lim;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_req.command == CMD_UPDATE && w_found) begin
                    n_state = S_UPD_INS;
                end else if (r_req.command == CMD_LIST && w_list_n != 5'd0) begin
                    n_state = S_LIST;
                end
            end
            S_UPD_INS: begin
                n_state = S_IDLE;
            end
            S_LIST: begin
                if (r_idx == IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl      = '{op: CELL_HOLD, match_en: 1'b0};
        w_pop_front = 1'b0;
        n_count     = r_count;
        n_pcount    = r_pcount;
        n_idx       = r_idx;
        n_n         = r_n;
        n_out_valid = 1'b0;
        n_out       = r_out;
        case (r_state)
            S_EXEC: begin
                n_out_valid = 1'b1;
                n_out       = '0;
                n_out.last  = 1'b1;
                case (r_req.command)
                    CMD_INSERT: begin
                        if (!w_full) begin
                            w_ctrl.op = CELL_INSERT;
                            n_count   = r_count + CNT_W'(1);
                            n_pcount  = r_pcount + CNT_W'(r_req.pending);
                        end
                        n_out.status         = w_full ? STAT_FULL : STAT_OK;
                        n_out.case_id_res    = r_req.case_id;
                        n_out.owner_id_res   = r_req.owner_id;
                        n_out.confidence_res = r_req.confidence;
                        n_out.pending_res    = r_req.pending;
                    end
                    CMD_UPDATE: begin
                        // Drop the first match now; re-insert next cycle.
                        w_ctrl = '{op: CELL_REMOVE, match_en: 1'b1};
                        if (w_found) begin
                            n_out_valid = 1'b0;
                            n_count     = r_count - CNT_W'(1);
                            n_pcount    = r_pcount - CNT_W'(|w_taken_pend);
                        end else begin
                            n_out.status = STAT_NOT_FOUND;
                        end
                    end
                    CMD_POP: begin
                        if (r_count == '0) begin
                            n_out.status = STAT_EMPTY;
                        end else begin
                            w_ctrl.op            = CELL_REMOVE;
                            w_pop_front          = 1'b1;
                            n_count              = r_count - CNT_W'(1);
                            n_pcount             = r_pcount - CNT_W'(w_rec[0].pending);
                            n_out.case_id_res    = w_rec[0].case_id;
                            n_out.owner_id_res   = w_rec[0].owner_id;
                            n_out.confidence_res = w_rec[0].confidence;
                            n_out.pending_res    = w_rec[0].pending;
                        end
                    end
                    CMD_LIST: begin
                        if (w_list_n == 5'd0) begin
                            n_out.status = (r_count == '0) ? STAT_EMPTY : STAT_OK;
                        end else begin
                            n_out_valid = 1'b0;
                            n_idx       = '0;
                            n_n         = w_list_n;
                        end
                    end
                    default: begin
                    end
                endcase
                n_out.total_count   = cnt5(n_count);
                n_out.pending_count = cnt5(n_pcount);
            end
            S_UPD_INS: begin
                w_ctrl.op   = CELL_INSERT;
                n_count     = r_count + CNT_W'(1);
                n_pcount    = r_pcount + CNT_W'(r_req.pending);
                n_out_valid = 1'b1;
                n_out       = '{status:         STAT_OK,
                                case_id_res:    r_req.case_id,
                                owner_id_res:   r_req.owner_id,
                                confidence_res: r_req.confidence,
                                pending_res:    r_req.pending,
                                total_count:    cnt5(n_count),
                                pending_count:  cnt5(n_pcount),
                                last:           1'b1};
            end
            S_LIST: begin
                // Stream cell 0 while rotating; finish the turn silently.
                w_ctrl.op = CELL_ROTATE;
                n_idx     = r_idx + IDX_W'(1);
                if (LW'(r_idx) < LW'(r_n)) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status:         STAT_OK,
                                    case_id_res:    w_rec[0].case_id,
                                    owner_id_res:   w_rec[0].owner_id,
                                    confidence_res: w_rec[0].confidence,
                                    pending_res:    w_rec[0].pending,
                                    total_count:    cnt5(r_count),
                                    pending_count:  cnt5(r_pcount),
                                    last:           (LW'(r_idx) + LW'(1)) == LW'(r_n)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pcount    <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pcount    <= n_pcount;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (start && !busy) begin
            r_req <= i_cmd;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`include "confidence_priority_queue_assert.svh"

    `CPQ_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "count overflow")
    `CPQ_ASSERT_IMPLY(a_pend_bound, 1'b1, r_pcount <= r_count, "pending exceeds held count")
    `CPQ_ASSERT_IMPLY(a_cells_match, r_state != S_LIST, $countones(w_valid) == int'(r_count), "cell occupancy disagrees with count")
    `CPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")

endmodule

`default_nettype wire
